>>> design/ubf_pkg.sv
// ----------------------------------------------------------------------------
// ubf_pkg
// Shared types and constants of the unmatched bracket finder: item, result
// and command layouts, report codes, bracket codes and character constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ubf_pkg;

  // default stack depth and internal queue depths
  localparam int unsigned StackDepthDefault = 32;
  localparam int unsigned CmdQueueDepth     = 2;
  localparam int unsigned ResQueueDepth     = 2;

  // counter limit for line and column
  localparam logic [15:0] CounterMax = 16'hFFFF;

  // item kinds
  localparam logic [1:0] KindChar = 2'd0;
  localparam logic [1:0] KindEol  = 2'd1;
  localparam logic [1:0] KindEot  = 2'd2;

  // report codes
  localparam logic [1:0] RepUnmatchedCloser = 2'd0;
  localparam logic [1:0] RepUnclosedOpener  = 2'd1;
  localparam logic [1:0] RepOverflow        = 2'd2;
  localparam logic [1:0] RepNothingOpen     = 2'd3;

  // bracket codes
  localparam logic [2:0] BrParenOpen  = 3'd0;
  localparam logic [2:0] BrSquareOpen = 3'd1;
  localparam logic [2:0] BrCurlyOpen  = 3'd2;
  localparam logic [2:0] BrParenClose  = 3'd3;
  localparam logic [2:0] BrSquareClose = 3'd4;
  localparam logic [2:0] BrCurlyClose  = 3'd5;
  localparam logic [2:0] CloseOffset   = 3'd3;

  // character bytes
  localparam logic [7:0] ChParenOpen   = 8'h28;
  localparam logic [7:0] ChSquareOpen  = 8'h5B;
  localparam logic [7:0] ChCurlyOpen   = 8'h7B;
  localparam logic [7:0] ChParenClose  = 8'h29;
  localparam logic [7:0] ChSquareClose = 8'h5D;
  localparam logic [7:0] ChCurlyClose  = 8'h7D;
  localparam logic [7:0] ChDoubleQuote = 8'h22;
  localparam logic [7:0] ChSingleQuote = 8'h27;
  localparam logic [7:0] ChSlash       = 8'h2F;
  localparam logic [7:0] ChBackslash   = 8'h5C;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic [1:0]  report;
    logic [15:0] line_no;
    logic [15:0] column;
    logic [2:0]  bracket_code;
    logic        last;
  } result_t;

  // commands from the front to the back
  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_DRAIN = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [15:0] line_no;
    logic [15:0] column;
    logic [2:0]  bracket_code;
  } cmd_t;

  // one stack entry: position and opener code
  typedef struct packed {
    logic [15:0] line_no;
    logic [15:0] column;
    logic [1:0]  code;
  } stack_entry_t;

endpackage

>>> design/unmatched_bracket_finder.sv
// Unmatched bracket finder. Source text enters one item per cycle (a byte,
// an end of line or an end of text) and the front end never stalls except
// when its two-entry command queue is full. Behind that queue the stack
// engine handles an opener, an unmatched closer or a matched closer that
// empties the stack in its run state alone; a matched closer that leaves
// openers below it also passes a refill state, which takes the new top,
// read from the stack memory, into the top register. At end of text it
// takes the command and walks the stack from the bottom, a read state and
// an output state per open bracket, as the stack memory has a single
// registered read port; an empty stack gives its one report from the run
// state. Results wait in a two-entry queue, so the engine keeps going while a result is not yet taken.
// ----------------------------------------------------------------------------
// unmatched_bracket_finder
// Top level: front end, command queue, stack engine and result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unmatched_bracket_finder #(
  parameter int unsigned STACK_DEPTH = ubf_pkg::StackDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  ubf_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output ubf_pkg::result_t result_o
);

  import ubf_pkg::*;

  logic    item_accept;
  logic    front_cmd_valid;
  cmd_t    front_cmd;
  logic    cmd_empty, cmd_pop;
  cmd_t    cmd_head;
  logic    res_full, res_push;
  result_t res_data;

  // transfer into the front end
  assign item_accept = push && !full;

  ubf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_accept),
    .item_i      (item_i),
    .cmd_valid_o (front_cmd_valid),
    .cmd_o       (front_cmd)
  );

  // command queue between front and back
  ubf_fifo #(
    .Width($bits(cmd_t)),
    .Depth(CmdQueueDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (item_accept && front_cmd_valid),
    .data_i (front_cmd),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_head),
    .empty_o(cmd_empty)
  );

  ubf_back #(
    .StackDepth(STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_data)
  );

  // result queue toward the output port
  ubf_fifo #(
    .Width($bits(result_t)),
    .Depth(ResQueueDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_data),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (result_o),
    .empty_o(empty)
  );

endmodule

>>> design/ubf_fifo.sv
// ----------------------------------------------------------------------------
// ubf_fifo
// Small first-in first-out queue in flip-flops, used between the front and
// the back and in front of the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> design/ubf_front.sv
// ----------------------------------------------------------------------------
// ubf_front
// Lexer front end: tracks line and column, strings, escapes and line
// comments, and turns each live bracket or end of text into a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  input  ubf_pkg::item_t item_i,
  output logic          cmd_valid_o,
  output ubf_pkg::cmd_t cmd_o
);

  import ubf_pkg::*;

  logic [15:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic        in_quote_q, in_quote_d;
  logic        quote_single_q, quote_single_d;
  logic        escape_q, escape_d;
  logic        slash_q, slash_d;
  logic        comment_q, comment_d;

  logic        is_bracket;
  logic [2:0]  br_code;
  logic        quote_char;

  // bracket decode of the incoming byte
  always_comb begin
    is_bracket = 1'b1;
    br_code    = BrParenOpen;
    case (item_i.ch)
      ChParenOpen:   br_code = BrParenOpen;
      ChSquareOpen:  br_code = BrSquareOpen;
      ChCurlyOpen:   br_code = BrCurlyOpen;
      ChParenClose:  br_code = BrParenClose;
      ChSquareClose: br_code = BrSquareClose;
      ChCurlyClose:  br_code = BrCurlyClose;
      default:       is_bracket = 1'b0;
    endcase
  end

  assign quote_char = quote_single_q ? (item_i.ch == ChSingleQuote)
                                     : (item_i.ch == ChDoubleQuote);

  // next lexer state and command
  always_comb begin
    line_d         = line_q;
    col_d          = col_q;
    in_quote_d     = in_quote_q;
    quote_single_d = quote_single_q;
    escape_d       = escape_q;
    slash_d        = slash_q;
    comment_d      = comment_q;
    cmd_valid_o    = 1'b0;
    cmd_o.op           = CMD_OPEN;
    cmd_o.line_no      = line_q;
    cmd_o.column       = col_q;
    cmd_o.bracket_code = br_code;
    if (item_valid_i) begin
      case (item_i.kind)
        KindChar: begin
          if (col_q != CounterMax) begin
            col_d = col_q + 16'd1;
          end
          if (comment_q) begin
            // rest of line ignored
          end else if (in_quote_q) begin
            if (escape_q) begin
              escape_d = 1'b0;
            end else if (item_i.ch == ChBackslash) begin
              escape_d = 1'b1;
            end else if (quote_char) begin
              in_quote_d = 1'b0;
            end
          end else if (item_i.ch == ChDoubleQuote || item_i.ch == ChSingleQuote) begin
            in_quote_d     = 1'b1;
            quote_single_d = (item_i.ch == ChSingleQuote);
            escape_d       = 1'b0;
            slash_d        = 1'b0;
          end else if (item_i.ch == ChSlash) begin
            if (slash_q) begin
              comment_d = 1'b1;
              slash_d   = 1'b0;
            end else begin
              slash_d = 1'b1;
            end
          end else begin
            slash_d     = 1'b0;
            cmd_valid_o = is_bracket;
            cmd_o.op    = (br_code >= BrParenClose) ? CMD_CLOSE : CMD_OPEN;
          end
        end
        KindEol: begin
          in_quote_d     = 1'b0;
          quote_single_d = 1'b0;
          escape_d       = 1'b0;
          slash_d        = 1'b0;
          comment_d      = 1'b0;
          col_d          = '0;
          if (line_q != CounterMax) begin
            line_d = line_q + 16'd1;
          end
        end
        KindEot: begin
          cmd_valid_o    = 1'b1;
          cmd_o.op       = CMD_DRAIN;
          line_d         = '0;
          col_d          = '0;
          in_quote_d     = 1'b0;
          quote_single_d = 1'b0;
          escape_d       = 1'b0;
          slash_d        = 1'b0;
          comment_d      = 1'b0;
        end
        default: begin
          // unused kind, no effect
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q         <= '0;
      col_q          <= '0;
      in_quote_q     <= 1'b0;
      quote_single_q <= 1'b0;
      escape_q       <= 1'b0;
      slash_q        <= 1'b0;
      comment_q      <= 1'b0;
    end else begin
      line_q         <= line_d;
      col_q          <= col_d;
      in_quote_q     <= in_quote_d;
      quote_single_q <= quote_single_d;
      escape_q       <= escape_d;
      slash_q        <= slash_d;
      comment_q      <= comment_d;
    end
  end

endmodule

>>> design/ubf_back.sv
// ----------------------------------------------------------------------------
// ubf_back
// Stack engine: pushes openers into the stack memory, matches closers
// against the top, and walks the stack from the bottom at end of text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubf_back #(
  parameter int unsigned StackDepth = ubf_pkg::StackDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  ubf_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output ubf_pkg::result_t res_o
);

  import ubf_pkg::*;

  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CntW  = $clog2(StackDepth + 1);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_REFILL,
    ST_DRAIN_RD,
    ST_DRAIN_OUT
  } state_e;

  state_e         state_q;
  logic [CntW-1:0] count_q;
  logic [1:0]     top_q;
  logic [AddrW-1:0] idx_q;

  stack_entry_t   stack_mem [StackDepth];
  stack_entry_t   rd_q;
  stack_entry_t   wr_data;
  logic           wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;

  logic           can_push, top_match, drain_last;

  assign can_push   = (count_q != CntW'(StackDepth));
  assign top_match  = (count_q != '0) &&
                      (({1'b0, top_q} + CloseOffset) == cmd_i.bracket_code);
  assign drain_last = ((CntW'(idx_q) + CntW'(1)) == count_q);

  // memory port control and result formation
  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.report       = RepUnmatchedCloser;
    res_o.line_no      = cmd_i.line_no;
    res_o.column       = cmd_i.column;
    res_o.bracket_code = cmd_i.bracket_code;
    res_o.last         = 1'b0;
    wr_en   = 1'b0;
    wr_addr = count_q[AddrW-1:0];
    wr_data.line_no = cmd_i.line_no;
    wr_data.column  = cmd_i.column;
    wr_data.code    = cmd_i.bracket_code[1:0];
    rd_en   = 1'b0;
    rd_addr = idx_q;
    case (state_q)
      ST_RUN: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            CMD_OPEN: begin
              if (can_push) begin
                wr_en = 1'b1;
              end else begin
                res_push_o   = 1'b1;
                res_o.report = RepOverflow;
              end
            end
            CMD_CLOSE: begin
              if (top_match) begin
                // fetch the entry that becomes the new top
                rd_en   = (count_q > CntW'(1));
                rd_addr = AddrW'(count_q - CntW'(2));
              end else begin
                res_push_o = 1'b1;
              end
            end
            CMD_DRAIN: begin
              if (count_q == '0) begin
                res_push_o         = 1'b1;
                res_o.report       = RepNothingOpen;
                res_o.line_no      = '0;
                res_o.column       = '0;
                res_o.bracket_code = BrParenOpen;
                res_o.last         = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN_RD: begin
        rd_en = 1'b1;
      end
      ST_DRAIN_OUT: begin
        res_o.report       = RepUnclosedOpener;
        res_o.line_no      = rd_q.line_no;
        res_o.column       = rd_q.column;
        res_o.bracket_code = {1'b0, rd_q.code};
        res_o.last         = drain_last;
        res_push_o         = !res_full_i;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      count_q <= '0;
      top_q   <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        ST_RUN: begin
          if (cmd_pop_o) begin
            case (cmd_i.op)
              CMD_OPEN: begin
                if (can_push) begin
                  count_q <= count_q + CntW'(1);
                  top_q   <= cmd_i.bracket_code[1:0];
                end
              end
              CMD_CLOSE: begin
                if (top_match) begin
                  count_q <= count_q - CntW'(1);
                  if (count_q > CntW'(1)) begin
                    state_q <= ST_REFILL;
                  end
                end
              end
              CMD_DRAIN: begin
                idx_q <= '0;
                if (count_q != '0) begin
                  state_q <= ST_DRAIN_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_REFILL: begin
          top_q   <= rd_q.code;
          state_q <= ST_RUN;
        end
        ST_DRAIN_RD: begin
          state_q <= ST_DRAIN_OUT;
        end
        ST_DRAIN_OUT: begin
          if (res_push_o) begin
            if (drain_last) begin
              count_q <= '0;
              state_q <= ST_RUN;
            end else begin
              idx_q   <= idx_q + AddrW'(1);
              state_q <= ST_DRAIN_RD;
            end
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  // stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= stack_mem[rd_addr];
    end
  end

  // stack never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(StackDepth))
    else $error("stack count above depth");

  // the final report of a drain leaves the stack empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last) |=> (count_q == '0))
    else $error("stack not cleared after end of text");

  // a top refetch only follows a matched closer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REFILL) |-> ($past(state_q) == ST_RUN && $past(cmd_pop_o)))
    else $error("refill without a matched closer");

  // a drain report is only formed after its memory read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN_OUT && $past(state_q) != ST_DRAIN_OUT) |->
      ($past(state_q) == ST_DRAIN_RD))
    else $error("drain report without read");

endmodule
